// File: design/assert_macros.svh
// Assertion macros shared by the checker files.
// Needs nothing but a clock and an active-low synchronous reset at the use site.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define OGR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");

// Checked on every rising edge, reset included.
`define OGR_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: check failed");

`endif

// File: design/ogr_pkg.sv
// Types and constants of the occupancy grid raycaster.
// Used by the top level and its checker; depends on nothing.
package ogr_pkg;

    localparam int GRID_SIZE_DEF = 256;

    // Field widths of the words on the ports.
    localparam int ACTION_W = 2;
    localparam int IN_W     = 12;
    localparam int CELL_W   = 2;

    // Walk position and error term widths (room for a step past the grid edge).
    localparam int COORD_W = 14;
    localparam int ERR_W   = 16;

    typedef logic [ACTION_W-1:0] t_action;
    localparam t_action ACT_INSERT = 2'd0;
    localparam t_action ACT_READ   = 2'd1;
    localparam t_action ACT_CLEAR  = 2'd2;

    typedef logic [CELL_W-1:0] t_cell;
    localparam t_cell CELL_UNKNOWN  = 2'd0;
    localparam t_cell CELL_FREE     = 2'd1;
    localparam t_cell CELL_OCCUPIED = 2'd2;
    localparam t_cell CELL_OUT      = 2'd3;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [ERR_W-1:0]   t_err;

endpackage

// File: design/ogr_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
// Generic; no package dependency.
module ogr_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_re) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: design/occupancy_grid_raycaster.sv
// Occupancy grid with Bresenham ray insertion, cell reads and a grid clear.
// Uses ogr_pkg and one ogr_ram instance that holds the grid.
//
//   channel  direction  handshake                 word
//   in       into block i_in_valid / o_in_stall   i_action, i_cell_x, i_cell_y
//   out      from block o_out_valid / i_out_stall o_cell_code, o_endpoint_marked
//
// One item at a time. Insert: accept, then a walk of one cell per step (each a
// read-modify-write of the grid RAM, overlapped with the next cell's read), a
// stop step, a mark step and the result. Read: accept, RAM read, result. Clear:
// sweeps all 4**clog2(GRID_SIZE) RAM words (65536 at the default), then result.
// Reset runs the same sweep with o_in_stall high before the first word is taken.
// A stalled result stays in the output register; the block waits to load the
// next one until that register is free.
module occupancy_grid_raycaster
    import ogr_pkg::*;
#(
    parameter int GRID_SIZE = GRID_SIZE_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [ACTION_W-1:0]  i_action,
    input  logic signed [IN_W-1:0] i_cell_x,
    input  logic signed [IN_W-1:0] i_cell_y,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [CELL_W-1:0]    o_cell_code,
    output logic                 o_endpoint_marked
);

    localparam int CW    = $clog2(GRID_SIZE);
    localparam int AW    = 2 * CW;
    localparam int DEPTH = 1 << AW;

    localparam t_coord GRID_C   = t_coord'(GRID_SIZE);
    localparam t_coord CENTER_C = t_coord'(GRID_SIZE / 2);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_WALK,
        S_MARK,
        S_RESULT
    } t_state;

    t_state          r_state;
    logic [AW-1:0]   r_clr_addr;
    logic            r_clr_reply;
    t_coord          r_x;
    t_coord          r_y;
    t_coord          r_xe;
    t_coord          r_ye;
    t_err            r_dx;
    t_err            r_dy;
    t_err            r_err;
    logic            r_sx_neg;
    logic            r_sy_neg;
    logic            r_end_in;
    logic            r_wr_pend;
    logic [AW-1:0]   r_wr_addr;
    t_cell           r_res_code;
    logic            r_res_mark;
    logic            r_out_valid;
    t_cell           r_cell_code;
    logic            r_endpoint_marked;

    // Input side decode
    logic            in_accept;
    t_coord          in_x;
    t_coord          in_y;
    logic            in_in_range;
    logic [AW-1:0]   in_addr;
    t_err            n_dx;
    t_err            n_dy;

    // Walk step
    logic            walk_in_range;
    logic            walk_at_end;
    logic [AW-1:0]   walk_addr;
    t_err            e2;
    logic            step_x;
    logic            step_y;
    t_err            n_err;

    // RAM ports
    logic            ram_we;
    logic [AW-1:0]   ram_wr_addr;
    t_cell           ram_wr_data;
    logic            ram_re;
    logic [AW-1:0]   ram_rd_addr;
    t_cell           ram_rd_data;

    logic            out_free;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    assign in_x = t_coord'(i_cell_x);
    assign in_y = t_coord'(i_cell_y);
    assign in_in_range = (in_x >= 0) && (in_x < GRID_C) && (in_y >= 0) && (in_y < GRID_C);
    assign in_addr = {in_x[CW-1:0], in_y[CW-1:0]};

    assign n_dx = (in_x > CENTER_C) ? t_err'(in_x - CENTER_C) : t_err'(CENTER_C - in_x);
    assign n_dy = (in_y > CENTER_C) ? t_err'(in_y - CENTER_C) : t_err'(CENTER_C - in_y);

    assign walk_in_range = (r_x >= 0) && (r_x < GRID_C) && (r_y >= 0) && (r_y < GRID_C);
    assign walk_at_end   = (r_x == r_xe) && (r_y == r_ye);
    assign walk_addr     = {r_x[CW-1:0], r_y[CW-1:0]};

    assign e2     = r_err <<< 1;
    assign step_x = (e2 > -r_dy);
    assign step_y = (e2 < r_dx);

    always_comb begin
        n_err = r_err;
        if (step_x) begin
            n_err = n_err - r_dy;
        end
        if (step_y) begin
            n_err = n_err + r_dx;
        end
    end

    // Read port: a read word at accept, or the next walk cell.
    always_comb begin
        ram_re      = 1'b0;
        ram_rd_addr = walk_addr;
        if (in_accept && (i_action == ACT_READ) && in_in_range) begin
            ram_re      = 1'b1;
            ram_rd_addr = in_addr;
        end else if ((r_state == S_WALK) && walk_in_range && !walk_at_end) begin
            ram_re = 1'b1;
        end
    end

    // Write port: clear sweep, endpoint mark, or finish the pending free write.
    always_comb begin
        ram_we      = 1'b0;
        ram_wr_addr = r_wr_addr;
        ram_wr_data = CELL_FREE;
        priority if (r_state == S_CLEAR) begin
            ram_we      = 1'b1;
            ram_wr_addr = r_clr_addr;
            ram_wr_data = CELL_UNKNOWN;
        end else if (r_state == S_MARK) begin
            ram_we      = r_end_in;
            ram_wr_addr = {r_xe[CW-1:0], r_ye[CW-1:0]};
            ram_wr_data = CELL_OCCUPIED;
        end else if (r_wr_pend) begin
            // occupied cells on the ray stay occupied
            ram_we = (ram_rd_data != CELL_OCCUPIED);
        end
    end

    ogr_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_grid (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_re      (ram_re),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_clr_reply <= 1'b0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
            r_x         <= '0;
            r_y         <= '0;
            r_err       <= '0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == '1) begin
                        r_state <= r_clr_reply ? S_RESULT : S_IDLE;
                    end
                end

                S_IDLE: begin
                    if (in_accept) begin
                        r_res_code <= CELL_UNKNOWN;
                        r_res_mark <= 1'b0;
                        unique case (i_action)
                            ACT_INSERT: begin
                                r_x      <= CENTER_C;
                                r_y      <= CENTER_C;
                                r_xe     <= in_x;
                                r_ye     <= in_y;
                                r_dx     <= n_dx;
                                r_dy     <= n_dy;
                                r_err    <= n_dx - n_dy;
                                r_sx_neg <= !(CENTER_C < in_x);
                                r_sy_neg <= !(CENTER_C < in_y);
                                r_end_in <= in_in_range;
                                r_state  <= S_WALK;
                            end
                            ACT_READ: begin
                                if (in_in_range) begin
                                    r_state <= S_READ;
                                end else begin
                                    r_res_code <= CELL_OUT;
                                    r_state    <= S_RESULT;
                                end
                            end
                            ACT_CLEAR: begin
                                r_clr_addr  <= '0;
                                r_clr_reply <= 1'b1;
                                r_state     <= S_CLEAR;
                            end
                            default: begin
                                r_state <= S_RESULT;
                            end
                        endcase
                    end
                end

                S_READ: begin
                    r_res_code <= ram_rd_data;
                    r_state    <= S_RESULT;
                end

                S_WALK: begin
                    if (!walk_in_range || walk_at_end) begin
                        // last pending write lands this cycle
                        r_wr_pend <= 1'b0;
                        r_state   <= S_MARK;
                    end else begin
                        r_wr_pend <= 1'b1;
                        r_wr_addr <= walk_addr;
                        r_err     <= n_err;
                        if (step_x) begin
                            r_x <= r_sx_neg ? r_x - 1'b1 : r_x + 1'b1;
                        end
                        if (step_y) begin
                            r_y <= r_sy_neg ? r_y - 1'b1 : r_y + 1'b1;
                        end
                    end
                end

                S_MARK: begin
                    r_res_mark <= r_end_in;
                    r_state    <= S_RESULT;
                end

                S_RESULT: begin
                    // hold until the output register is free
                    if (out_free) begin
                        r_out_valid       <= 1'b1;
                        r_cell_code       <= r_res_code;
                        r_endpoint_marked <= r_res_mark;
                        r_clr_reply       <= 1'b0;
                        r_state           <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_cell_code       = r_cell_code;
    assign o_endpoint_marked = r_endpoint_marked;

endmodule

// File: design/ogr_checker.sv
// Port-level checks of the occupancy grid raycaster, bound to its top level.
// Uses ogr_pkg and the macros of assert_macros.svh.
`include "assert_macros.svh"

module ogr_checker
    import ogr_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic [CELL_W-1:0]   o_cell_code,
    input logic                o_endpoint_marked
);

    // A stalled result word holds.
    `OGR_ASSERT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_cell_code) && $stable(o_endpoint_marked))

    // One word in flight: the block stalls right after taking a word.
    `OGR_ASSERT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && !o_in_stall |=> o_in_stall)

    // A result is either a read code or an insert mark, never both.
    `OGR_ASSERT(a_one_kind, i_clk, i_rst_n,
        o_out_valid |-> !(o_endpoint_marked && (o_cell_code != CELL_UNKNOWN)))

    // Reset starts the clearing sweep with no result pending.
    `OGR_ASSERT_ALWAYS(a_reset_sweep, i_clk, !i_rst_n |=> o_in_stall && !o_out_valid)

endmodule

bind occupancy_grid_raycaster ogr_checker u_ogr_checker (.*);

// File: sim/tb_occupancy_grid_raycaster.sv
// Testbench for occupancy_grid_raycaster: ray inserts, cell reads and grid clears
// checked word by word against a grid model kept here. Depends on ogr_pkg and the RTL.
`timescale 1ns / 1ps

module tb_occupancy_grid_raycaster;
    import ogr_pkg::*;

    localparam int GRID = GRID_SIZE_DEF;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 300;
    localparam t_action ACT_UNUSED = 2'd3;

    typedef struct packed {
        t_cell code;
        logic  marked;
    } t_result_word;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    t_action                i_action;
    logic signed [IN_W-1:0] i_cell_x;
    logic signed [IN_W-1:0] i_cell_y;
    logic                   o_out_valid;
    logic                   i_out_stall;
    t_cell                  o_cell_code;
    logic                   o_endpoint_marked;

    t_cell        grid_model [GRID*GRID];
    t_result_word due_results [$];
    t_result_word want;
    int unsigned  mismatch_count = 0;
    int unsigned  cycle_count = 0;
    bit           tx_idle = 1'b0;
    bit           rx_idle = 1'b0;
    bit           hold_out_req = 1'b0;
    int           last_hit_x = GRID / 2;
    int           last_hit_y = GRID / 2;

    occupancy_grid_raycaster #(.GRID_SIZE(GRID)) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_cell_x         (i_cell_x),
        .i_cell_y         (i_cell_y),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_cell_code      (o_cell_code),
        .o_endpoint_marked(o_endpoint_marked)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------- grid model ----------------

    function automatic bit cell_in_grid(int x, int y);
        return x >= 0 && x < GRID && y >= 0 && y < GRID;
    endfunction

    function automatic void wipe_grid_model();
        foreach (grid_model[i]) grid_model[i] = CELL_UNKNOWN;
    endfunction

    // Walk from the centre toward the hit; free cells up to the endpoint or the edge.
    function automatic void cast_hit_ray(int xe, int ye);
        int x, y, dx, dy, sx, sy, err, e2;
        x = GRID / 2;
        y = GRID / 2;
        dx = (xe > x) ? xe - x : x - xe;
        dy = (ye > y) ? ye - y : y - ye;
        sx = (x < xe) ? 1 : -1;
        sy = (y < ye) ? 1 : -1;
        err = dx - dy;
        while (1) begin
            if (!cell_in_grid(x, y)) break;
            if (x == xe && y == ye) break;
            if (grid_model[x*GRID + y] != CELL_OCCUPIED)
                grid_model[x*GRID + y] = CELL_FREE;
            e2 = 2 * err;
            if (e2 > -dy) begin
                err -= dy;
                x += sx;
            end
            if (e2 < dx) begin
                err += dx;
                y += sy;
            end
        end
    endfunction

    function automatic t_result_word apply_grid_word(t_action act,
                                                     logic signed [IN_W-1:0] cx,
                                                     logic signed [IN_W-1:0] cy);
        t_result_word r;
        int x, y;
        x = int'(cx);
        y = int'(cy);
        r.code = CELL_UNKNOWN;
        r.marked = 1'b0;
        case (act)
            ACT_INSERT: begin
                cast_hit_ray(x, y);
                if (cell_in_grid(x, y)) begin
                    grid_model[x*GRID + y] = CELL_OCCUPIED;
                    r.marked = 1'b1;
                end
            end
            ACT_READ: begin
                r.code = cell_in_grid(x, y) ? grid_model[x*GRID + y] : CELL_OUT;
            end
            ACT_CLEAR: begin
                wipe_grid_model();
            end
            default: ;
        endcase
        return r;
    endfunction

    // ---------------- drivers ----------------

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 96) return $urandom_range(15, 4);
        return $urandom_range(80, 20);
    endfunction

    // Hold the word until taken, then log its expected result.
    task automatic send_word(t_action act, int cx, int cy);
        int unsigned gap;
        logic signed [IN_W-1:0] wx;
        logic signed [IN_W-1:0] wy;
        wx = IN_W'(cx);
        wy = IN_W'(cy);
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_cell_x   <= wx;
        i_cell_y   <= wy;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        due_results.push_back(apply_grid_word(act, wx, wy));
        gap = tx_idle ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        int unsigned n;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_out_req) begin
                // long hold-off so the block backs up into its input
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_out_req = 1'b0;
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else if (rx_idle) begin
                n = pick_gap();
                if (n > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                end
                i_out_stall <= 1'b0;
                repeat ($urandom_range(6, 1)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_results.size() == 0) begin
                $display("%0t: unexpected word: expected none, actual code %0d marked %0d",
                         $time, o_cell_code, o_endpoint_marked);
                mismatch_count++;
            end else begin
                want = due_results.pop_front();
                if (o_cell_code !== want.code) begin
                    $display("%0t: cell_code mismatch: expected %0d, actual %0d",
                             $time, want.code, o_cell_code);
                    mismatch_count++;
                end
                if (o_endpoint_marked !== want.marked) begin
                    $display("%0t: endpoint_marked mismatch: expected %0d, actual %0d",
                             $time, want.marked, o_endpoint_marked);
                    mismatch_count++;
                end
            end
        end
    end

    // ---------------- stimulus ----------------

    // Wraps to the 12-bit field when driven.
    function automatic int pick_coord();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70) return int'($urandom_range(GRID - 1));
        if (r < 85) return int'($urandom_range(GRID + 39)) - 20;
        return int'($urandom_range(4095));
    endfunction

    task automatic send_random_word(ref int clears_left);
        int unsigned r;
        int x, y;
        r = $urandom_range(999);
        x = pick_coord();
        y = pick_coord();
        if (r < 2 && clears_left > 0) begin
            clears_left--;
            send_word(ACT_CLEAR, x, y);
        end else if (r < 30) begin
            send_word(ACT_UNUSED, x, y);
        end else if (r < 500) begin
            last_hit_x = x;
            last_hit_y = y;
            send_word(ACT_INSERT, x, y);
        end else if (r < 650) begin
            send_word(ACT_READ, last_hit_x, last_hit_y);
        end else if (r < 850) begin
            // roughly halfway along the last ray: mostly free cells
            send_word(ACT_READ, GRID/2 + (last_hit_x - GRID/2) / 2,
                      GRID/2 + (last_hit_y - GRID/2) / 2);
        end else begin
            send_word(ACT_READ, x, y);
        end
    endtask

    task automatic test_directed();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        send_word(ACT_READ, GRID/2, GRID/2);
        send_word(ACT_READ, -1, 5);
        send_word(ACT_READ, GRID, 0);
        send_word(ACT_READ, 0, GRID);
        send_word(ACT_INSERT, GRID/2, GRID/2);
        send_word(ACT_READ, GRID/2, GRID/2);
        // occupied cell on a later ray must stay occupied
        send_word(ACT_INSERT, GRID/2 + 3, GRID/2);
        send_word(ACT_INSERT, GRID/2 + 12, GRID/2);
        send_word(ACT_READ, GRID/2 + 3, GRID/2);
        send_word(ACT_READ, GRID/2 + 7, GRID/2);
        send_word(ACT_INSERT, 0, 0);
        send_word(ACT_INSERT, GRID - 1, GRID - 1);
        send_word(ACT_INSERT, -2048, 2047);
        send_word(ACT_INSERT, 2047, -2048);
        send_word(ACT_READ, GRID/4, GRID/4);
        send_word(ACT_INSERT, GRID/2, 0);
        send_word(ACT_INSERT, 0, GRID/2);
        send_word(ACT_UNUSED, 2047, -2048);
        send_word(ACT_READ, -2048, -2048);
        send_word(ACT_READ, 2047, 2047);
        send_word(ACT_READ, GRID - 1, 0);
        send_word(ACT_CLEAR, 0, 0);
        send_word(ACT_READ, GRID/2, GRID/2);
        send_word(ACT_READ, 0, 0);
    endtask

    task automatic test_random_rays();
        int clears_left;
        clears_left = 2;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        repeat (900) send_random_word(clears_left);
    endtask

    task automatic test_back_to_back();
        int clears_left;
        clears_left = 0;
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        repeat (150) send_random_word(clears_left);
    endtask

    task automatic test_output_hold();
        int clears_left;
        clears_left = 0;
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        repeat (2) begin
            hold_out_req = 1'b1;
            repeat (60) send_random_word(clears_left);
        end
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_action   <= ACT_READ;
        i_cell_x   <= '0;
        i_cell_y   <= '0;
        wipe_grid_model();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_rays();
        test_back_to_back();
        test_output_hold();

        i_in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: occupancy_grid_raycaster.f
+incdir+design
design/ogr_pkg.sv
design/ogr_ram.sv
design/occupancy_grid_raycaster.sv
design/ogr_checker.sv
sim/tb_occupancy_grid_raycaster.sv
